### sv/two_lane_demand_traffic_light_core_macros.svh
// Assertion macros for the two-lane demand traffic light core.
// Included by the top level; expects clk and rst_n in scope.
`ifndef TWO_LANE_DEMAND_TRAFFIC_LIGHT_CORE_MACROS_SVH
`define TWO_LANE_DEMAND_TRAFFIC_LIGHT_CORE_MACROS_SVH

// Check a consequence in the same cycle as its cause
`define TLDL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause
`define TLDL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/tldl_pkg.sv
// Shared types and constants for the two-lane demand traffic light core.
// No dependencies; used by tldl_step and the top level.
package tldl_pkg;

    // Default widths of sensor samples and the phase timer
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int TIMER_BITS_DEF  = 16;

    // Configuration register widths
    localparam int THR_BITS     = 10;
    localparam int CFG_BITS     = 16;
    localparam int CFG_IDX_BITS = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SAFETY    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_GREEN = 2'd2;

    // Configuration reset values
    localparam logic [THR_BITS-1:0] THRESHOLD_RST = 10'd300;
    localparam logic [CFG_BITS-1:0] SAFETY_RST    = 16'd1000;
    localparam logic [CFG_BITS-1:0] MIN_GREEN_RST = 16'd5000;

    // Sequence phase codes
    localparam int PHASE_BITS = 3;
    localparam logic [PHASE_BITS-1:0] PH_IDLE         = 3'd0;
    localparam logic [PHASE_BITS-1:0] PH_OFF_YELLOW   = 3'd1;
    localparam logic [PHASE_BITS-1:0] PH_OFF_RED      = 3'd2;
    localparam logic [PHASE_BITS-1:0] PH_ON_REDYELLOW = 3'd3;
    localparam logic [PHASE_BITS-1:0] PH_ON_GREEN     = 3'd4;

    // Lane bookkeeping beside the phase and timer
    typedef struct packed {
        logic       served;
        logic [1:0] green;
        logic       first;
    } ctrl_t;

    // Lamps of both lanes for one tick, index is the lane
    typedef struct packed {
        logic [1:0] red;
        logic [1:0] yellow;
        logic [1:0] green;
        logic       busy;
    } lamp_t;

endpackage

### sv/two_lane_demand_traffic_light_core.sv
// Two-lane demand traffic light core: one sensor item per timer tick.
// Depends on tldl_pkg, tldl_step and the macro header.
// Lamp results are registered and shown in the cycle after their transfer.
// Throughput: one item per cycle, stalled only while a held result waits.
// Reset: sequencer idle, no lane green, first change pending; lamp outputs
// not reset; threshold 300, safety 1000 ticks, minimum green 5000 ticks.
`include "two_lane_demand_traffic_light_core_macros.svh"

module two_lane_demand_traffic_light_core #(
    parameter int SAMPLE_BITS = tldl_pkg::SAMPLE_BITS_DEF,
    parameter int TIMER_BITS  = tldl_pkg::TIMER_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [tldl_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [tldl_pkg::CFG_BITS-1:0]     cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [SAMPLE_BITS-1:0]            lane0_sample,
    input  logic [SAMPLE_BITS-1:0]            lane1_sample,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              lane0_red,
    output logic                              lane0_yellow,
    output logic                              lane0_green,
    output logic                              lane1_red,
    output logic                              lane1_yellow,
    output logic                              lane1_green,
    output logic                              sequence_busy
);

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    logic [tldl_pkg::THR_BITS-1:0]   threshold_reg;
    logic [tldl_pkg::CFG_BITS-1:0]   safety_reg;
    logic [tldl_pkg::CFG_BITS-1:0]   min_green_reg;
    logic [TIMER_BITS-1:0]           safety_len;
    logic [TIMER_BITS-1:0]           green_len;
    logic [tldl_pkg::PHASE_BITS-1:0] phase_reg;
    logic [tldl_pkg::PHASE_BITS-1:0] phase_next;
    logic [TIMER_BITS-1:0]           timer_reg;
    logic [TIMER_BITS-1:0]           timer_next;
    tldl_pkg::ctrl_t                 ctrl_reg;
    tldl_pkg::ctrl_t                 ctrl_next;
    tldl_pkg::lamp_t                 lamps_next;
    tldl_pkg::lamp_t                 lamps_reg;
    logic                            out_valid_reg;
    logic                            in_xfer;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            threshold_reg <= tldl_pkg::THRESHOLD_RST;
            safety_reg    <= tldl_pkg::SAFETY_RST;
            min_green_reg <= tldl_pkg::MIN_GREEN_RST;
        end
        else if (cfg_wr_en) begin
            unique case (cfg_index)
                tldl_pkg::CFG_THRESHOLD: threshold_reg <= cfg_data[tldl_pkg::THR_BITS-1:0];
                tldl_pkg::CFG_SAFETY:    safety_reg    <= cfg_data;
                tldl_pkg::CFG_MIN_GREEN: min_green_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Fit phase lengths into the timer, saturating on a short timer
    generate
        if (TIMER_BITS >= tldl_pkg::CFG_BITS) begin : g_wide_timer
            assign safety_len = TIMER_BITS'(safety_reg);
            assign green_len  = TIMER_BITS'(min_green_reg);
        end
        else begin : g_short_timer
            assign safety_len = (safety_reg > tldl_pkg::CFG_BITS'(TIMER_MAX)) ?
                                TIMER_MAX : safety_reg[TIMER_BITS-1:0];
            assign green_len  = (min_green_reg > tldl_pkg::CFG_BITS'(TIMER_MAX)) ?
                                TIMER_MAX : min_green_reg[TIMER_BITS-1:0];
        end
    endgenerate

    // Stall input only while a held result is not taken
    assign in_stall = out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;

    tldl_step #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .lane0_sample(lane0_sample),
        .lane1_sample(lane1_sample),
        .threshold   (threshold_reg),
        .safety_len  (safety_len),
        .green_len   (green_len),
        .phase_cur   (phase_reg),
        .timer_cur   (timer_reg),
        .ctrl_cur    (ctrl_reg),
        .phase_nxt   (phase_next),
        .timer_nxt   (timer_next),
        .ctrl_nxt    (ctrl_next),
        .lamps       (lamps_next)
    );

    // Advance sequencer state on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= tldl_pkg::PH_IDLE;
            timer_reg <= '0;
            ctrl_reg  <= '{served: 1'b0, green: 2'b00, first: 1'b1};
        end
        else if (in_xfer) begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            ctrl_reg  <= ctrl_next;
        end
    end

    // Hold result valid until the transfer out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer) begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load lamp result on each input transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer) begin
            lamps_reg <= lamps_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign lane0_red     = lamps_reg.red[0];
    assign lane0_yellow  = lamps_reg.yellow[0];
    assign lane0_green   = lamps_reg.green[0];
    assign lane1_red     = lamps_reg.red[1];
    assign lane1_yellow  = lamps_reg.yellow[1];
    assign lane1_green   = lamps_reg.green[1];
    assign sequence_busy = lamps_reg.busy;

    // Both lanes are never green together
    `TLDL_ASSERT_SAME(a_no_double_green, out_valid_reg, !(lane0_green && lane1_green), "both lanes green")
    // Idle controller never shows yellow
    `TLDL_ASSERT_SAME(a_idle_no_yellow, out_valid_reg && !sequence_busy, !lane0_yellow && !lane1_yellow, "yellow while idle")
    // Idle phase keeps a cleared timer
    `TLDL_ASSERT_SAME(a_idle_timer, phase_reg == tldl_pkg::PH_IDLE, timer_reg == '0, "idle timer not zero")
    // A transfer in always yields a valid result next cycle
    `TLDL_ASSERT_NEXT(a_xfer_result, in_xfer, out_valid_reg, "result lost after transfer")

endmodule

### sv/tldl_step.sv
// One-tick next-state and lamp logic of the traffic light sequencer.
// Depends on tldl_pkg; purely combinational, instantiated by the top level.
module tldl_step #(
    parameter int SAMPLE_BITS = tldl_pkg::SAMPLE_BITS_DEF,
    parameter int TIMER_BITS  = tldl_pkg::TIMER_BITS_DEF
) (
    input  logic [SAMPLE_BITS-1:0]          lane0_sample,
    input  logic [SAMPLE_BITS-1:0]          lane1_sample,
    input  logic [tldl_pkg::THR_BITS-1:0]   threshold,
    input  logic [TIMER_BITS-1:0]           safety_len,
    input  logic [TIMER_BITS-1:0]           green_len,
    input  logic [tldl_pkg::PHASE_BITS-1:0] phase_cur,
    input  logic [TIMER_BITS-1:0]           timer_cur,
    input  tldl_pkg::ctrl_t                 ctrl_cur,
    output logic [tldl_pkg::PHASE_BITS-1:0] phase_nxt,
    output logic [TIMER_BITS-1:0]           timer_nxt,
    output tldl_pkg::ctrl_t                 ctrl_nxt,
    output tldl_pkg::lamp_t                 lamps
);

    localparam int CMP_BITS = (SAMPLE_BITS > tldl_pkg::THR_BITS) ?
                              SAMPLE_BITS : tldl_pkg::THR_BITS;

    typedef struct packed {
        logic [tldl_pkg::PHASE_BITS-1:0] phase;
        logic [TIMER_BITS-1:0]           timer;
        tldl_pkg::ctrl_t                 ctrl;
    } seq_t;

    // Enter a phase: load its length, light the served lane on red+yellow
    function automatic seq_t enter_phase(seq_t s, logic [tldl_pkg::PHASE_BITS-1:0] p,
                                         logic [TIMER_BITS-1:0] saf,
                                         logic [TIMER_BITS-1:0] grn);
        seq_t r;
        r = s;
        r.phase = p;
        unique case (p) inside
            tldl_pkg::PH_OFF_YELLOW, tldl_pkg::PH_OFF_RED:
            begin
                r.timer = saf;
            end
            tldl_pkg::PH_ON_REDYELLOW:
            begin
                r.ctrl.green[s.ctrl.served] = 1'b1;
                r.timer = saf;
            end
            tldl_pkg::PH_ON_GREEN:
            begin
                r.timer = grn;
            end
            default:
            begin
                r.phase = tldl_pkg::PH_IDLE;
                r.timer = '0;
            end
        endcase
        return r;
    endfunction

    // Skip expired phases; at most four steps from yellow to idle
    function automatic seq_t settle(seq_t s, logic [TIMER_BITS-1:0] saf,
                                    logic [TIMER_BITS-1:0] grn);
        seq_t r;
        r = s;
        for (int i = 0; i < 4; i++) begin
            if (r.phase != tldl_pkg::PH_IDLE && r.timer == '0) begin
                if (r.phase == tldl_pkg::PH_ON_GREEN) begin
                    r = enter_phase(r, tldl_pkg::PH_IDLE, saf, grn);
                end
                else begin
                    r = enter_phase(r, tldl_pkg::PHASE_BITS'(r.phase + 1'b1), saf, grn);
                end
            end
        end
        return r;
    endfunction

    seq_t s_in;
    seq_t s_pre;
    seq_t s_start;
    seq_t s_run;
    logic req0;
    logic req1;
    logic other;

    // Settle, look at the sensors when idle, then settle the new sequence
    always_comb
    begin
        s_in  = '{phase: phase_cur, timer: timer_cur, ctrl: ctrl_cur};
        s_pre = settle(s_in, safety_len, green_len);
        req0  = (CMP_BITS'(lane0_sample) > CMP_BITS'(threshold)) && !s_pre.ctrl.green[0];
        req1  = (CMP_BITS'(lane1_sample) > CMP_BITS'(threshold)) && !s_pre.ctrl.green[1];
        s_start = s_pre;
        other   = 1'b0;
        if (s_pre.phase == tldl_pkg::PH_IDLE && (req0 || req1)) begin
            s_start.ctrl.served = !req0;
            if (s_pre.ctrl.first) begin
                s_start.ctrl.first = 1'b0;
                s_start = enter_phase(s_start, tldl_pkg::PH_ON_REDYELLOW,
                                      safety_len, green_len);
            end
            else begin
                other = req0;
                s_start.ctrl.green[other] = 1'b0;
                s_start = enter_phase(s_start, tldl_pkg::PH_OFF_YELLOW,
                                      safety_len, green_len);
            end
        end
        s_run = settle(s_start, safety_len, green_len);
    end

    // Drive lamps from lane state, overlay yellow phases
    always_comb
    begin
        for (int k = 0; k < 2; k++) begin
            lamps.red[k]    = !s_run.ctrl.green[k];
            lamps.yellow[k] = 1'b0;
            lamps.green[k]  = s_run.ctrl.green[k];
        end
        if (s_run.phase == tldl_pkg::PH_OFF_YELLOW) begin
            lamps.red[!s_run.ctrl.served]    = 1'b0;
            lamps.yellow[!s_run.ctrl.served] = 1'b1;
            lamps.green[!s_run.ctrl.served]  = 1'b0;
        end
        else if (s_run.phase == tldl_pkg::PH_ON_REDYELLOW) begin
            lamps.red[s_run.ctrl.served]    = 1'b1;
            lamps.yellow[s_run.ctrl.served] = 1'b1;
            lamps.green[s_run.ctrl.served]  = 1'b0;
        end
        lamps.busy = (s_run.phase != tldl_pkg::PH_IDLE);
    end

    // Advance the phase timer by one tick
    always_comb
    begin
        phase_nxt = s_run.phase;
        ctrl_nxt  = s_run.ctrl;
        timer_nxt = s_run.timer;
        if (s_run.phase != tldl_pkg::PH_IDLE && s_run.timer != '0) begin
            timer_nxt = s_run.timer - TIMER_BITS'(1);
        end
    end

endmodule
